[sv/ugid_pkg.sv]
// ugid_pkg: shared types and constants for the UTF-8 glyph index decoder.
// No dependencies; compile first.
`timescale 1ns / 1ps

package ugid_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int LEN_W   = 3;
	localparam int BLEFT_W = 2;
	localparam int GC_W    = 22;

	localparam logic [GC_W-1:0] GLYPH_COUNT_RST = GC_W'(256);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CONT = 2'd1,
		ST_BAD_LEAD = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [BLEFT_W-1:0] bytes_left;
		logic [CP_W-1:0]    code_accum;
		logic [LEN_W-1:0]   seq_len;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		status_t          status;
	} dec_result_t;

endpackage

[sv/ugid_if.sv]
// Channel interfaces of the decoder: byte input, result output, config write.
// Depends on ugid_pkg.
`timescale 1ns / 1ps

interface ugid_byte_if;
	logic                      valid;
	logic                      ready;
	logic [ugid_pkg::BYTE_W-1:0] byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface ugid_result_if;
	logic                       valid;
	logic                       ready;
	logic [ugid_pkg::CP_W-1:0]  code_point;
	logic [ugid_pkg::LEN_W-1:0] seq_length;
	ugid_pkg::status_t          status;
	modport source (output valid, output code_point, output seq_length, output status,
		input ready);
	modport sink   (input valid, input code_point, input seq_length, input status,
		output ready);
endinterface

interface ugid_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ugid_pkg::GC_W-1:0] glyph_count;
	modport source (output valid, output glyph_count, input ready);
	modport sink   (input valid, input glyph_count, output ready);
endinterface

[sv/ugid_step.sv]
// ugid_step: combinational decode of one byte against the running sequence state.
// Depends on ugid_pkg.
`timescale 1ns / 1ps

module ugid_step (
	input  ugid_pkg::dec_state_t            st,
	input  logic [ugid_pkg::BYTE_W-1:0]     byte_in,
	input  logic [ugid_pkg::GC_W-1:0]       glyph_count,
	output ugid_pkg::dec_state_t            st_nxt,
	output logic                            res_valid,
	output ugid_pkg::dec_result_t           res
);
	import ugid_pkg::*;

	logic [CP_W-1:0] acc_shift;

	function automatic status_t range_chk(input logic [CP_W-1:0] cp,
		input logic [GC_W-1:0] gc);
		return ({1'b0, cp} >= gc) ? ST_RANGE : ST_OK;
	endfunction

	assign acc_shift = {st.code_accum[CP_W-7:0], byte_in[5:0]};

	always_comb begin
		st_nxt    = st;
		res_valid = 1'b0;
		res       = '{code_point: '0, seq_length: '0, status: ST_OK};
		if (st.bytes_left == '0) begin
			case (byte_in) inside
				[8'h00:8'h7F]: begin
					res_valid      = 1'b1;
					res.code_point = CP_W'(byte_in);
					res.seq_length = LEN_W'(1);
					res.status     = range_chk(CP_W'(byte_in), glyph_count);
				end
				[8'hC0:8'hDF]: begin
					st_nxt.code_accum = CP_W'(byte_in[4:0]);
					st_nxt.seq_len    = LEN_W'(2);
					st_nxt.bytes_left = BLEFT_W'(1);
				end
				[8'hE0:8'hEF]: begin
					st_nxt.code_accum = CP_W'(byte_in[3:0]);
					st_nxt.seq_len    = LEN_W'(3);
					st_nxt.bytes_left = BLEFT_W'(2);
				end
				[8'hF0:8'hF7]: begin
					st_nxt.code_accum = CP_W'(byte_in[2:0]);
					st_nxt.seq_len    = LEN_W'(4);
					st_nxt.bytes_left = BLEFT_W'(3);
				end
				default: begin
					// stray continuation or 0xF8 and above
					res_valid      = 1'b1;
					res.seq_length = LEN_W'(1);
					res.status     = ST_BAD_LEAD;
				end
			endcase
		end else if (byte_in[7:6] != 2'b10) begin
			res_valid      = 1'b1;
			res.seq_length = st.seq_len - LEN_W'(st.bytes_left) + LEN_W'(1);
			res.status     = ST_BAD_CONT;
			st_nxt         = '0;
		end else begin
			st_nxt.code_accum = acc_shift;
			st_nxt.bytes_left = st.bytes_left - BLEFT_W'(1);
			if (st.bytes_left == BLEFT_W'(1)) begin
				res_valid      = 1'b1;
				res.code_point = acc_shift;
				res.seq_length = st.seq_len;
				res.status     = range_chk(acc_shift, glyph_count);
				st_nxt         = '0;
			end
		end
	end

endmodule

[sv/utf8_glyph_index_decoder_core.sv]
// Top level of the UTF-8 glyph index decoder: state, config and result registers.
// Depends on ugid_pkg, ugid_if.sv and ugid_step.
//
//   channel    dir  payload                            handshake
//   byte_ch    in   byte_in[7:0]                       valid/ready
//   result_ch  out  code_point[20:0] seq_length[2:0]   valid/ready
//                   status[1:0]
//   cfg_ch     in   glyph_count[21:0]                  valid/ready (always ready)
//
// One byte per cycle; a result shows in the cycle after the byte that ends it.
// Throughput is set by the single result register: a byte is taken whenever that
// register is empty or is being read in the same cycle.
// Reset clears the sequence state, empties the result register, glyph_count = 256.
// A stalled result holds and blocks further bytes until taken.
`timescale 1ns / 1ps

module utf8_glyph_index_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	ugid_byte_if.sink      byte_ch,
	ugid_result_if.source  result_ch,
	ugid_cfg_if.sink       cfg_ch
);
	import ugid_pkg::*;

	dec_state_t        st_q, st_nxt;
	dec_result_t       res_d, res_q;
	logic              res_valid_d, out_valid_q;
	logic [GC_W-1:0]   glyph_count_q;
	logic              byte_acc;

	assign cfg_ch.ready  = 1'b1;
	assign byte_ch.ready = !out_valid_q || result_ch.ready;
	assign byte_acc      = byte_ch.valid && byte_ch.ready;

	ugid_step u_step (
		.st          (st_q),
		.byte_in     (byte_ch.byte_in),
		.glyph_count (glyph_count_q),
		.st_nxt      (st_nxt),
		.res_valid   (res_valid_d),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			out_valid_q   <= 1'b0;
			glyph_count_q <= GLYPH_COUNT_RST;
		end else begin
			if (cfg_ch.valid) begin
				glyph_count_q <= cfg_ch.glyph_count;
			end
			if (byte_acc) begin
				st_q        <= st_nxt;
				out_valid_q <= res_valid_d;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc && res_valid_d) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.code_point = res_q.code_point;
	assign result_ch.seq_length = res_q.seq_length;
	assign result_ch.status     = res_q.status;

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_ch.ready) |-> !byte_acc)
		else $error("byte taken while result stalled");

	a_len_covers_left: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.bytes_left != '0) |-> (st_q.seq_len > LEN_W'(st_q.bytes_left)))
		else $error("sequence length below bytes left");

	a_idle_accum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.bytes_left == '0) |-> (st_q.code_accum == '0 && st_q.seq_len == '0))
		else $error("stale accumulator outside a sequence");

	a_bad_lead_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == ST_BAD_LEAD) |->
		(res_q.seq_length == LEN_W'(1) && res_q.code_point == '0))
		else $error("bad lead result malformed");

endmodule

[bench/ugid_checker.sv]
// ugid_checker: watches the byte, result and config channels of the decoder,
// predicts each result from the accepted bytes and compares it field by field.
// Depends on ugid_pkg and the channel interfaces in ugid_if.sv.
`timescale 1ns / 1ps

module ugid_checker (
	input  logic   clk,
	input  logic   arst_n,
	ugid_byte_if   byte_ch,
	ugid_result_if result_ch,
	ugid_cfg_if    cfg_ch,
	output int     fail_count,
	output int     pending
);
	import ugid_pkg::*;

	logic [GC_W-1:0]    glyph_count;
	logic [BLEFT_W-1:0] cont_left;
	logic [CP_W-1:0]    accum;
	logic [LEN_W-1:0]   seq_len;
	dec_result_t        decoded_q[$];
	dec_result_t        want;
	dec_result_t        fresh;
	bit                 emit;

	function automatic status_t range_check(input logic [CP_W-1:0] cp);
		return ({1'b0, cp} >= glyph_count) ? ST_RANGE : ST_OK;
	endfunction

	task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit hit,
		output dec_result_t r);
		logic [LEN_W-1:0] n;
		hit = 1'b0;
		r = '0;
		r.status = ST_OK;
		if (cont_left == '0) begin
			if (b < 8'h80) begin
				hit = 1'b1;
				r.code_point = CP_W'(b);
				r.seq_length = LEN_W'(1);
				r.status = range_check(CP_W'(b));
			end else if (b < 8'hC0 || b >= 8'hF8) begin
				hit = 1'b1;
				r.seq_length = LEN_W'(1);
				r.status = ST_BAD_LEAD;
			end else begin
				n = (b < 8'hE0) ? LEN_W'(2) : (b < 8'hF0) ? LEN_W'(3) : LEN_W'(4);
				accum = CP_W'(b & (8'h7F >> n));
				seq_len = n;
				cont_left = BLEFT_W'(n - 1);
			end
		end else if (b[7:6] != 2'b10) begin
			// offending byte is swallowed along with the partial sequence
			hit = 1'b1;
			r.seq_length = seq_len - LEN_W'(cont_left) + LEN_W'(1);
			r.status = ST_BAD_CONT;
			cont_left = '0;
			accum = '0;
			seq_len = '0;
		end else begin
			accum = {accum[CP_W-7:0], b[5:0]};
			cont_left = cont_left - BLEFT_W'(1);
			if (cont_left == '0) begin
				hit = 1'b1;
				r.code_point = accum;
				r.seq_length = seq_len;
				r.status = range_check(accum);
				accum = '0;
				seq_len = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count = GLYPH_COUNT_RST;
			cont_left = '0;
			accum = '0;
			seq_len = '0;
			decoded_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result beat: code_point %h seq_length %0d status %0d",
						$time, result_ch.code_point, result_ch.seq_length, result_ch.status);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (result_ch.code_point !== want.code_point) begin
						$display("%0t: code_point expected %h actual %h",
							$time, want.code_point, result_ch.code_point);
						fail_count++;
					end
					if (result_ch.seq_length !== want.seq_length) begin
						$display("%0t: seq_length expected %0d actual %0d",
							$time, want.seq_length, result_ch.seq_length);
						fail_count++;
					end
					if (result_ch.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result_ch.status);
						fail_count++;
					end
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.byte_in, emit, fresh);
				if (emit)
					decoded_q.push_back(fresh);
			end
			if (cfg_ch.valid && cfg_ch.ready)
				glyph_count = cfg_ch.glyph_count;
			pending = decoded_q.size();
		end
	end

endmodule

[bench/testbench.sv]
// testbench: drives bytes and glyph_count writes into the UTF-8 glyph index
// decoder with bursty input and a stalling receiver; ugid_checker judges results.
// Depends on ugid_pkg, ugid_if.sv, utf8_glyph_index_decoder_core and ugid_checker.
`timescale 1ns / 1ps

module testbench;
	import ugid_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 190;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   burst_left = 0;
	int   phase_bytes;
	int   idle_cycles = 0;
	int   stall_mode = 0;
	int   stall_left = 0;
	bit   quiet;

	logic [GC_W-1:0] glyph_settings[8] = '{
		GC_W'(0), GC_W'(1), GC_W'(128), GC_W'(2097152),
		GC_W'(12'h800), GC_W'(17'h10000), GC_W'(0), GC_W'(21'h110000)
	};

	logic [BYTE_W-1:0] directed[23] = '{
		8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
		8'hC3, 8'hA9, 8'hDF, 8'hBF,
		8'hE2, 8'h82, 8'hAC,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hC3, 8'h41,
		8'hE2, 8'h82, 8'hC0,
		8'hF0, 8'hFF
	};

	ugid_byte_if   byte_ch ();
	ugid_result_if result_ch ();
	ugid_cfg_if    cfg_ch ();

	utf8_glyph_index_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	ugid_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch),
		.cfg_ch     (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: stretches of always-ready, coin-flip and mostly-stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(0, 1));
			default: result_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= b;
		do @(posedge clk); while (!byte_ch.ready);
		@(negedge clk);
		phase_bytes++;
	endtask

	task automatic drain;
		byte_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_glyph_count(input logic [GC_W-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.glyph_count <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] lead_of(input int n);
		case (n)
			2: return 8'hC0 | BYTE_W'($urandom_range(0, 31));
			3: return 8'hE0 | BYTE_W'($urandom_range(0, 15));
			default: return 8'hF0 | BYTE_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic put_sequence;
		int kind;
		int n;
		int k;
		logic [BYTE_W-1:0] b;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			put_byte(BYTE_W'($urandom_range(0, 127)));
		end else if (kind < 80) begin
			n = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
			put_byte(lead_of(n));
			repeat (n - 1) put_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
		end else if (kind < 90) begin
			// truncated sequence ended by a byte that is not a continuation
			n = $urandom_range(2, 4);
			k = $urandom_range(0, n - 2);
			put_byte(lead_of(n));
			repeat (k) put_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
			b = BYTE_W'($urandom_range(0, 255));
			if (b[7:6] == 2'b10)
				b[6] = 1'b1;
			put_byte(b);
		end else begin
			put_byte(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.glyph_count = '0;
		result_ch.ready = 1'b0;
		quiet = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset glyph_count first, then the widest setting
		foreach (directed[i])
			put_byte(directed[i]);
		set_glyph_count(GC_W'(2097152));
		foreach (directed[i])
			put_byte(directed[i]);

		for (int p = 0; p < 8; p++) begin
			if (p == 6)
				glyph_settings[p] = GC_W'($urandom_range(0, 2097152));
			set_glyph_count(glyph_settings[p]);
			quiet = (p == 3);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				put_sequence();
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
sv/ugid_pkg.sv
sv/ugid_if.sv
sv/ugid_step.sv
sv/utf8_glyph_index_decoder_core.sv
bench/ugid_checker.sv
bench/testbench.sv
